FILE: hdl/sbcp_pkg.sv
// Shared constants and types for the segment/box crossing block.
package sbcp_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int QWidth     = FracBits + 1;
  localparam int WideWidth  = CoordWidth + 1;
  localparam int NumAxes    = 3;
  localparam int NumRegs    = 6;
  localparam int IdxWidth   = 3;

  localparam logic [QWidth-1:0] QOne = QWidth'(1) << FracBits;

  localparam logic [IdxWidth-1:0] RegMinX = 3'd0;
  localparam logic [IdxWidth-1:0] RegMaxX = 3'd1;
  localparam logic [IdxWidth-1:0] RegMinY = 3'd2;
  localparam logic [IdxWidth-1:0] RegMaxY = 3'd3;
  localparam logic [IdxWidth-1:0] RegMinZ = 3'd4;
  localparam logic [IdxWidth-1:0] RegMaxZ = 3'd5;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [WideWidth-1:0]  wide_t;
  typedef logic [QWidth-1:0]            frac_t;

  typedef struct packed {
    coord_t min_v;
    coord_t max_v;
  } bounds_t;

  // The face coordinate can sit one LSB outside the coordinate range until the clamp.
  typedef struct packed {
    logic  ok;
    frac_t q;
    wide_t  p0;
    coord_t p1;
    coord_t p2;
  } axis_res_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    logic   entering;
  } seg_t;

  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
    coord_t cross_z;
    frac_t  fraction;
  } result_t;

endpackage

FILE: hdl/sbcp_if.sv
// Valid/ready channel interfaces for segments, results and register writes.
interface sbcp_seg_if (input logic clk);
  logic valid;
  logic ready;
  sbcp_pkg::coord_t start_x;
  sbcp_pkg::coord_t start_y;
  sbcp_pkg::coord_t start_z;
  sbcp_pkg::coord_t end_x;
  sbcp_pkg::coord_t end_y;
  sbcp_pkg::coord_t end_z;
  logic entering;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, entering,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z, entering,
                output ready);
endinterface

interface sbcp_res_if (input logic clk);
  logic valid;
  logic ready;
  logic hit;
  sbcp_pkg::coord_t cross_x;
  sbcp_pkg::coord_t cross_y;
  sbcp_pkg::coord_t cross_z;
  sbcp_pkg::frac_t fraction;
  modport source (output valid, hit, cross_x, cross_y, cross_z, fraction, input ready);
  modport sink (input valid, hit, cross_x, cross_y, cross_z, fraction, output ready);
endinterface

interface sbcp_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [sbcp_pkg::IdxWidth-1:0] index;
  sbcp_pkg::coord_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/segment_box_crossing_point.sv
// Top level: register file, pipeline control, three axis units and winner select.
//
//  channel | dir | payload
//  in_     | in  | start_x/y/z, end_x/y/z, entering
//  out_    | out | hit, cross_x/y/z, fraction
//  cfg_    | in  | index, data (box bounds)
//
// One segment is accepted per cycle while out_ does not stall the pipeline.
// The pipeline depth is set mainly by the one-bit-per-stage fraction divider in each axis unit.
// Reset clears the box registers and all valid bits.
// A stall on out_ freezes the whole pipeline; nothing is lost or repeated.
module segment_box_crossing_point (
  input logic clk,
  input logic rst_n,
  sbcp_seg_if.sink   in_ch,
  sbcp_res_if.source out_ch,
  sbcp_cfg_if.sink   cfg_ch
);
  localparam int Depth = sbcp_pkg::FracBits + 4;

  sbcp_pkg::coord_t box_r [sbcp_pkg::NumRegs];
  sbcp_pkg::bounds_t bx, by, bz;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbcp_pkg::NumRegs; i++) box_r[i] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        sbcp_pkg::RegMinX: box_r[0] <= cfg_ch.data;
        sbcp_pkg::RegMaxX: box_r[1] <= cfg_ch.data;
        sbcp_pkg::RegMinY: box_r[2] <= cfg_ch.data;
        sbcp_pkg::RegMaxY: box_r[3] <= cfg_ch.data;
        sbcp_pkg::RegMinZ: box_r[4] <= cfg_ch.data;
        sbcp_pkg::RegMaxZ: box_r[5] <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign bx = '{min_v: box_r[0], max_v: box_r[1]};
  assign by = '{min_v: box_r[2], max_v: box_r[3]};
  assign bz = '{min_v: box_r[4], max_v: box_r[5]};

  // Whole pipeline advances together; the last stage is the output register.
  logic en;
  logic [Depth-1:0] vld_r;
  logic [Depth-1:0] ent_r;
  assign en = !vld_r[Depth-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Depth-2:0], in_ch.valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) ent_r <= {ent_r[Depth-2:0], in_ch.entering};
  end

  sbcp_pkg::axis_res_t rx, ry, rz;
  sbcp_axis u_ax (.clk(clk), .en(en),
    .sa(in_ch.start_x), .ea(in_ch.end_x), .sb(in_ch.start_y), .eb(in_ch.end_y),
    .sc(in_ch.start_z), .ec(in_ch.end_z), .bnd_a(bx), .bnd_b(by), .bnd_c(bz),
    .entering(in_ch.entering), .res(rx));
  sbcp_axis u_ay (.clk(clk), .en(en),
    .sa(in_ch.start_y), .ea(in_ch.end_y), .sb(in_ch.start_z), .eb(in_ch.end_z),
    .sc(in_ch.start_x), .ec(in_ch.end_x), .bnd_a(by), .bnd_b(bz), .bnd_c(bx),
    .entering(in_ch.entering), .res(ry));
  sbcp_axis u_az (.clk(clk), .en(en),
    .sa(in_ch.start_z), .ea(in_ch.end_z), .sb(in_ch.start_x), .eb(in_ch.end_x),
    .sc(in_ch.start_y), .ec(in_ch.end_y), .bnd_a(bz), .bnd_b(bx), .bnd_c(by),
    .entering(in_ch.entering), .res(rz));

  // Winner select; ties keep the earlier axis. Axis unit outputs are rotated.
  sbcp_pkg::result_t win, out_r;
  sbcp_pkg::wide_t wx, wy, wz;
  logic ent;
  assign ent = ent_r[Depth-2];
  always_comb begin
    win = '0;
    wx = '0; wy = '0; wz = '0;
    if (rx.ok) begin
      win.hit = 1'b1; win.fraction = rx.q;
      wx = rx.p0;
      wy = sbcp_pkg::wide_t'(rx.p1);
      wz = sbcp_pkg::wide_t'(rx.p2);
    end
    if (ry.ok && (!win.hit || ry.q < win.fraction)) begin
      win.hit = 1'b1; win.fraction = ry.q;
      wx = sbcp_pkg::wide_t'(ry.p2);
      wy = ry.p0;
      wz = sbcp_pkg::wide_t'(ry.p1);
    end
    if (rz.ok && (!win.hit || rz.q < win.fraction)) begin
      win.hit = 1'b1; win.fraction = rz.q;
      wx = sbcp_pkg::wide_t'(rz.p1);
      wy = sbcp_pkg::wide_t'(rz.p2);
      wz = rz.p0;
    end
    if (win.hit && ent) begin
      if (wx < sbcp_pkg::wide_t'(bx.min_v)) wx = sbcp_pkg::wide_t'(bx.min_v);
      else if (wx > sbcp_pkg::wide_t'(bx.max_v)) wx = sbcp_pkg::wide_t'(bx.max_v);
      if (wy < sbcp_pkg::wide_t'(by.min_v)) wy = sbcp_pkg::wide_t'(by.min_v);
      else if (wy > sbcp_pkg::wide_t'(by.max_v)) wy = sbcp_pkg::wide_t'(by.max_v);
      if (wz < sbcp_pkg::wide_t'(bz.min_v)) wz = sbcp_pkg::wide_t'(bz.min_v);
      else if (wz > sbcp_pkg::wide_t'(bz.max_v)) wz = sbcp_pkg::wide_t'(bz.max_v);
    end
    win.cross_x = sbcp_pkg::CoordWidth'(wx);
    win.cross_y = sbcp_pkg::CoordWidth'(wy);
    win.cross_z = sbcp_pkg::CoordWidth'(wz);
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= win;
  end

  assign out_ch.valid    = vld_r[Depth-1];
  assign out_ch.hit      = out_r.hit;
  assign out_ch.cross_x  = out_r.cross_x;
  assign out_ch.cross_y  = out_r.cross_y;
  assign out_ch.cross_z  = out_r.cross_z;
  assign out_ch.fraction = out_r.fraction;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("pipeline moved during stall");
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |-> out_ch.fraction == '0 && out_ch.cross_x == '0)
    else $error("miss with nonzero payload");
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> out_ch.fraction <= sbcp_pkg::QOne)
    else $error("fraction above one");
endmodule

FILE: hdl/sbcp_div.sv
// Pipelined restoring divider: |num|/|den| to FracBits fraction bits, one bit per stage.
module sbcp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sbcp_pkg::WideWidth-1:0] an,
  input  logic [sbcp_pkg::WideWidth-1:0] ad,
  output logic [sbcp_pkg::FracBits-1:0] q
);
  localparam int W = sbcp_pkg::WideWidth;
  localparam int F = sbcp_pkg::FracBits;

  logic [W:0]   rem_r [F+1];
  logic [W-1:0] den_r [F+1];
  logic [F-1:0] q_r   [F+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, an};
      den_r[0] <= ad;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_bit
    logic [W+1:0] sh;
    logic         ge;
    assign sh = {rem_r[k], 1'b0};
    assign ge = sh >= {2'b00, den_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (W+1)'(sh - {2'b00, den_r[k]}) : sh[W:0];
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= {q_r[k][F-2:0], ge};
      end
    end
  end

  assign q = q_r[F];
endmodule

FILE: hdl/sbcp_axis.sv
// One axis of the slab test: plane choice, fraction, interpolation and face check.
module sbcp_axis (
  input  logic                clk,
  input  logic                en,
  input  sbcp_pkg::coord_t    sa,
  input  sbcp_pkg::coord_t    ea,
  input  sbcp_pkg::coord_t    sb,
  input  sbcp_pkg::coord_t    eb,
  input  sbcp_pkg::coord_t    sc,
  input  sbcp_pkg::coord_t    ec,
  input  sbcp_pkg::bounds_t   bnd_a,
  input  sbcp_pkg::bounds_t   bnd_b,
  input  sbcp_pkg::bounds_t   bnd_c,
  input  logic                entering,
  output sbcp_pkg::axis_res_t res
);
  localparam int W  = sbcp_pkg::WideWidth;
  localparam int F  = sbcp_pkg::FracBits;
  localparam int QW = sbcp_pkg::QWidth;
  localparam int L  = F + 1;  // divider latency
  localparam int PW = W + QW + 1;

  typedef struct packed {
    logic   fwd;
    logic   dead;
    logic   sat;
    logic   one;
    logic   zero;
    sbcp_pkg::wide_t  pa;
    sbcp_pkg::coord_t sb;
    sbcp_pkg::wide_t  db;
    sbcp_pkg::coord_t sc;
    sbcp_pkg::wide_t  dc;
  } side_t;

  // Stage 1: plane, numerator, denominator.
  logic fwd;
  sbcp_pkg::wide_t plane, num, den;
  logic [W-1:0] an, ad;
  side_t s1, s1_r;

  always_comb begin
    fwd   = ea > sa;
    plane = (fwd == entering) ? W'(bnd_a.min_v) : W'(bnd_a.max_v) - W'(1);
    den   = W'(ea) - W'(sa);
    num   = plane - W'(sa);
    an    = num[W-1] ? W'(-num) : W'(num);
    ad    = den[W-1] ? W'(-den) : W'(den);
    s1.fwd  = fwd;
    s1.zero = (num == '0);
    s1.dead = (den == '0) || (!s1.zero && (num[W-1] != den[W-1]));
    s1.sat  = an > ad;
    s1.one  = an == ad;
    s1.pa   = fwd ? plane + W'(1) : plane;
    s1.sb   = sb;
    s1.db   = W'(eb) - W'(sb);
    s1.sc   = sc;
    s1.dc   = W'(ec) - W'(sc);
  end

  logic [F-1:0] q_div;
  sbcp_div u_div (.clk(clk), .en(en), .an(an), .ad(ad), .q(q_div));

  side_t side_r [L];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s1;
      for (int i = 1; i < L; i++) side_r[i] <= side_r[i-1];
    end
  end
  assign s1_r = side_r[L-1];

  // Stage: fraction resolve and validity.
  sbcp_pkg::frac_t q;
  logic qok;
  always_comb begin
    if (s1_r.zero)     q = '0;
    else if (s1_r.sat) q = sbcp_pkg::QOne + QW'(1);
    else if (s1_r.one) q = sbcp_pkg::QOne;
    else               q = {1'b0, q_div};
    qok = !s1_r.dead && (s1_r.fwd ? (q < sbcp_pkg::QOne)
                                  : (q != '0 && q <= sbcp_pkg::QOne));
  end

  // Multiply stage: magnitude times fraction, registered.
  logic ok_m_r;
  sbcp_pkg::frac_t q_m_r;
  sbcp_pkg::wide_t pa_m_r;
  sbcp_pkg::coord_t sb_m_r, sc_m_r;
  logic nb_m_r, nc_m_r;
  logic [PW-1:0] pb_m_r, pc_m_r;
  logic [W-1:0] mb, mc;
  assign mb = s1_r.db[W-1] ? W'(-s1_r.db) : W'(s1_r.db);
  assign mc = s1_r.dc[W-1] ? W'(-s1_r.dc) : W'(s1_r.dc);
  always_ff @(posedge clk) begin
    if (en) begin
      ok_m_r <= qok;
      q_m_r  <= q;
      pa_m_r <= s1_r.pa;
      sb_m_r <= s1_r.sb;
      sc_m_r <= s1_r.sc;
      nb_m_r <= s1_r.db[W-1];
      nc_m_r <= s1_r.dc[W-1];
      pb_m_r <= PW'(mb) * PW'(q);
      pc_m_r <= PW'(mc) * PW'(q);
    end
  end

  // Final stage: add, range check.
  sbcp_pkg::wide_t vb, vc;
  logic [W-1:0] rb, rc;
  logic inb;
  always_comb begin
    rb  = W'(pb_m_r >> F);
    rc  = W'(pc_m_r >> F);
    vb  = W'(sb_m_r) + (nb_m_r ? W'(-rb) : rb);
    vc  = W'(sc_m_r) + (nc_m_r ? W'(-rc) : rc);
    inb = vb >= W'(bnd_b.min_v) && vb < W'(bnd_b.max_v) &&
          vc >= W'(bnd_c.min_v) && vc < W'(bnd_c.max_v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.ok <= ok_m_r && inb;
      res.q  <= q_m_r;
      res.p0 <= pa_m_r;
      res.p1 <= sbcp_pkg::CoordWidth'(vb);
      res.p2 <= sbcp_pkg::CoordWidth'(vc);
    end
  end
endmodule

FILE: dv/sbcp_checker.sv
// Checker for the segment/box crossing block: predicts each crossing and compares results.
`timescale 1ns / 100ps

module sbcp_checker (
  input  logic clk,
  input  logic rst_n,
  sbcp_seg_if  in_ch,
  sbcp_res_if  out_ch,
  sbcp_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);

  localparam longint One = longint'(1) << sbcp_pkg::FracBits;
  localparam longint FracMask = One - 1;

  sbcp_pkg::coord_t  box_lo [sbcp_pkg::NumAxes];
  sbcp_pkg::coord_t  box_hi [sbcp_pkg::NumAxes];
  sbcp_pkg::result_t crossing_q [$];

  // Product of a signed span and a fraction, truncated toward zero.
  function automatic longint scale_span(longint d, longint q);
    longint m;
    longint r;
    m = (d < 0) ? -d : d;
    r = (m >>> sbcp_pkg::FracBits) * q + (((m & FracMask) * q) >>> sbcp_pkg::FracBits);
    return (d < 0) ? -r : r;
  endfunction

  function automatic sbcp_pkg::result_t predict_crossing(sbcp_pkg::seg_t sg);
    longint  s [sbcp_pkg::NumAxes];
    longint  e [sbcp_pkg::NumAxes];
    longint  lo [sbcp_pkg::NumAxes];
    longint  hi [sbcp_pkg::NumAxes];
    longint  pt [sbcp_pkg::NumAxes];
    longint  best [sbcp_pkg::NumAxes];
    longint  plane, den, num, an, ad, rem, q, best_q;
    bit      hit, fwd, ok;
    int      b, c;
    sbcp_pkg::result_t r;
    s[0] = sg.start_x; s[1] = sg.start_y; s[2] = sg.start_z;
    e[0] = sg.end_x;   e[1] = sg.end_y;   e[2] = sg.end_z;
    for (int i = 0; i < sbcp_pkg::NumAxes; i++) begin
      lo[i] = box_lo[i];
      hi[i] = box_hi[i];
      best[i] = 0;
      pt[i] = 0;
    end
    hit = 0;
    best_q = 0;
    for (int a = 0; a < sbcp_pkg::NumAxes; a++) begin
      b = (a + 1) % sbcp_pkg::NumAxes;
      c = (a + 2) % sbcp_pkg::NumAxes;
      ok = 1;
      fwd = e[a] > s[a];
      plane = ((s[a] < e[a]) == sg.entering) ? lo[a] : hi[a] - 1;
      den = e[a] - s[a];
      num = plane - s[a];
      q = 0;
      if (den == 0) begin
        ok = 0;
      end else if (num != 0) begin
        if ((num > 0) != (den > 0)) begin
          ok = 0;
        end else begin
          an = (num < 0) ? -num : num;
          ad = (den < 0) ? -den : den;
          if (an > ad) begin
            q = One + 1;
          end else if (an == ad) begin
            q = One;
          end else begin
            rem = an;
            for (int k = 0; k < sbcp_pkg::FracBits; k++) begin
              rem = rem << 1;
              q = q << 1;
              if (rem >= ad) begin
                rem = rem - ad;
                q = q | 1;
              end
            end
          end
        end
      end
      if (ok && (fwd ? (q >= One) : (q == 0 || q > One))) ok = 0;
      if (ok) begin
        pt[a] = fwd ? plane + 1 : plane;
        pt[b] = s[b] + scale_span(e[b] - s[b], q);
        pt[c] = s[c] + scale_span(e[c] - s[c], q);
        if (pt[b] < lo[b] || pt[b] >= hi[b] || pt[c] < lo[c] || pt[c] >= hi[c])
          ok = 0;
      end
      // Strictly smaller wins, so earlier axes keep ties.
      if (ok && (!hit || q < best_q)) begin
        hit = 1;
        best_q = q;
        best = pt;
      end
    end
    if (hit && sg.entering) begin
      for (int a = 0; a < sbcp_pkg::NumAxes; a++) begin
        if (best[a] < lo[a]) best[a] = lo[a];
        else if (best[a] > hi[a]) best[a] = hi[a];
      end
    end
    r.hit      = hit;
    r.cross_x  = hit ? sbcp_pkg::coord_t'(best[0]) : '0;
    r.cross_y  = hit ? sbcp_pkg::coord_t'(best[1]) : '0;
    r.cross_z  = hit ? sbcp_pkg::coord_t'(best[2]) : '0;
    r.fraction = hit ? sbcp_pkg::frac_t'(best_q) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    sbcp_pkg::seg_t    sg;
    sbcp_pkg::result_t got;
    sbcp_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < sbcp_pkg::NumAxes; i++) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
      end
      crossing_q.delete();
      errors = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < sbcp_pkg::NumRegs) begin
        if (cfg_ch.index[0]) box_hi[cfg_ch.index[sbcp_pkg::IdxWidth-1:1]] = cfg_ch.data;
        else box_lo[cfg_ch.index[sbcp_pkg::IdxWidth-1:1]] = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        sg.start_x  = in_ch.start_x;
        sg.start_y  = in_ch.start_y;
        sg.start_z  = in_ch.start_z;
        sg.end_x    = in_ch.end_x;
        sg.end_y    = in_ch.end_y;
        sg.end_z    = in_ch.end_z;
        sg.entering = in_ch.entering;
        crossing_q.push_back(predict_crossing(sg));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.hit      = out_ch.hit;
        got.cross_x  = out_ch.cross_x;
        got.cross_y  = out_ch.cross_y;
        got.cross_z  = out_ch.cross_z;
        got.fraction = out_ch.fraction;
        if (crossing_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result at %0t: hit %0b", $time, got.hit);
        end else begin
          want = crossing_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display({"Mismatch at %0t: exp hit %0b x %0d y %0d z %0d f %0d, ",
                        "got hit %0b x %0d y %0d z %0d f %0d"},
                       $time, want.hit, want.cross_x, want.cross_y, want.cross_z,
                       want.fraction, got.hit, got.cross_x, got.cross_y, got.cross_z,
                       got.fraction);
          end
        end
      end
    end
    pending = crossing_q.size();
  end

endmodule

FILE: dv/segment_box_crossing_point_tb.sv
// Testbench top for the segment/box crossing block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module segment_box_crossing_point_tb;

  localparam int Limit = 400000;
  localparam sbcp_pkg::coord_t Ten = 32'sd655360;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_req;
  int   cycles;
  int   sent;

  sbcp_seg_if in_ch (clk);
  sbcp_res_if out_ch (clk);
  sbcp_cfg_if cfg_ch (clk);

  segment_box_crossing_point u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sbcp_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > Limit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side; a long hold-off is counted down here.
  always @(negedge clk) begin
    static int hold_cnt = 0;
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic sbcp_pkg::seg_t make_seg(sbcp_pkg::coord_t sx, sbcp_pkg::coord_t sy,
                                              sbcp_pkg::coord_t sz, sbcp_pkg::coord_t ex,
                                              sbcp_pkg::coord_t ey, sbcp_pkg::coord_t ez,
                                              logic ent);
    sbcp_pkg::seg_t sg;
    sg.start_x = sx; sg.start_y = sy; sg.start_z = sz;
    sg.end_x = ex;   sg.end_y = ey;   sg.end_z = ez;
    sg.entering = ent;
    return sg;
  endfunction

  // Mostly near the box, sometimes on a face or anywhere at all.
  function automatic sbcp_pkg::coord_t pick_coord(sbcp_pkg::coord_t lo, sbcp_pkg::coord_t hi);
    longint span;
    longint v;
    longint unsigned r;
    case ($urandom_range(0, 9))
      0: return sbcp_pkg::coord_t'($urandom);
      1: return lo;
      2: return hi - 1;
      3: return hi;
      default: begin
        span = longint'(hi) - longint'(lo);
        if (span <= 0) span = 64'd1 << 20;
        r = {$urandom, $urandom};
        v = longint'(lo) - span / 2 + longint'(r % longint'(2 * span + 1));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return sbcp_pkg::coord_t'(v);
      end
    endcase
  endfunction

  task automatic send_segment(sbcp_pkg::seg_t sg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.start_x  <= sg.start_x;
    in_ch.start_y  <= sg.start_y;
    in_ch.start_z  <= sg.start_z;
    in_ch.end_x    <= sg.end_x;
    in_ch.end_y    <= sg.end_y;
    in_ch.end_z    <= sg.end_z;
    in_ch.entering <= sg.entering;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [sbcp_pkg::IdxWidth-1:0] idx, sbcp_pkg::coord_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_box(sbcp_pkg::coord_t x0, sbcp_pkg::coord_t x1,
                          sbcp_pkg::coord_t y0, sbcp_pkg::coord_t y1,
                          sbcp_pkg::coord_t z0, sbcp_pkg::coord_t z1);
    write_reg(sbcp_pkg::RegMinX, x0);
    write_reg(sbcp_pkg::RegMaxX, x1);
    write_reg(sbcp_pkg::RegMinY, y0);
    write_reg(sbcp_pkg::RegMaxY, y1);
    write_reg(sbcp_pkg::RegMinZ, z0);
    write_reg(sbcp_pkg::RegMaxZ, z1);
    // Writes past the register file must leave the box alone.
    write_reg(sbcp_pkg::IdxWidth'(sbcp_pkg::NumRegs + 1), sbcp_pkg::coord_t'($urandom));
  endtask

  task automatic random_segments(int count);
    sbcp_pkg::seg_t sg;
    for (int i = 0; i < count; i++) begin
      if (sent < 400) begin
        send_idle_pct = 28;
        recv_idle_pct = 88;
      end else if (sent < 800) begin
        send_idle_pct = 88;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (sent == 900) hold_req = 1;
      sg = make_seg(pick_coord(u_checker.box_lo[0], u_checker.box_hi[0]),
                    pick_coord(u_checker.box_lo[1], u_checker.box_hi[1]),
                    pick_coord(u_checker.box_lo[2], u_checker.box_hi[2]),
                    pick_coord(u_checker.box_lo[0], u_checker.box_hi[0]),
                    pick_coord(u_checker.box_lo[1], u_checker.box_hi[1]),
                    pick_coord(u_checker.box_lo[2], u_checker.box_hi[2]),
                    1'($urandom_range(0, 1)));
      send_segment(sg);
    end
  endtask

  task automatic random_box(int unsigned width_max);
    sbcp_pkg::coord_t lo [3];
    sbcp_pkg::coord_t hi [3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = sbcp_pkg::coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      hi[a] = lo[a] + sbcp_pkg::coord_t'($urandom_range(1, width_max));
    end
    load_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_z = '0;
    in_ch.end_x = '0;   in_ch.end_y = '0;   in_ch.end_z = '0;
    in_ch.entering = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A few requests against the reset box, which is empty.
    send_segment(make_seg(-Ten, 0, 0, Ten, 0, 0, 1'b1));
    send_segment(make_seg(Ten, 0, 0, -Ten, 0, 0, 1'b0));
    wait_drained();

    // Directed requests against a box of +-10 on every axis.
    load_box(-Ten, Ten, -Ten, Ten, -Ten, Ten);
    send_segment(make_seg(-2 * Ten, 0, 0, 2 * Ten, 0, 0, 1'b1));
    send_segment(make_seg(-2 * Ten, 0, 0, 2 * Ten, 0, 0, 1'b0));
    send_segment(make_seg(2 * Ten, 5, -7, -2 * Ten, 5, -7, 1'b1));
    send_segment(make_seg(2 * Ten, 5, -7, -2 * Ten, 5, -7, 1'b0));
    // Equal fractions on all three axes.
    send_segment(make_seg(-2 * Ten, -2 * Ten, -2 * Ten, 2 * Ten, 2 * Ten, 2 * Ten, 1'b1));
    send_segment(make_seg(2 * Ten, 2 * Ten, 2 * Ten, -2 * Ten, -2 * Ten, -2 * Ten, 1'b0));
    // Zero length segment.
    send_segment(make_seg(0, 0, 0, 0, 0, 0, 1'b1));
    // Starts exactly on the lower and the upper face, and an end exactly on the upper face.
    send_segment(make_seg(-Ten, 1, 1, Ten, 1, 1, 1'b1));
    send_segment(make_seg(Ten - 1, 1, 1, -Ten, 1, 1, 1'b1));
    send_segment(make_seg(0, 0, 0, Ten - 1, 3, 3, 1'b0));
    // Segment that stops short of the face, so the quotient saturates.
    send_segment(make_seg(-3 * Ten, 0, 0, -2 * Ten, 0, 0, 1'b1));
    // Moving away from the face gives a negative quotient.
    send_segment(make_seg(-2 * Ten, 0, 0, -3 * Ten, 0, 0, 1'b1));
    // Extreme coordinates.
    send_segment(make_seg(32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1));
    send_segment(make_seg(32'sh7fffffff, 32'sh80000000, 0,
                          32'sh80000000, 32'sh7fffffff, 0, 1'b0));
    send_segment(make_seg(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 1'b1));
    send_segment(make_seg(-1, -1, -1, 1, 1, 1, 1'b0));
    wait_drained();

    // Widest box possible.
    load_box(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff);
    send_segment(make_seg(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 1'b1));
    send_segment(make_seg(32'sh7fffffff, 7, 7, 32'sh80000000, 7, 7, 1'b0));
    random_segments(150);
    wait_drained();

    random_box(1 << 20);
    random_segments(300);
    wait_drained();

    // Inverted box, which no segment can cross, so no result is a hit.
    load_box(Ten, -Ten, Ten, -Ten, Ten, -Ten);
    random_segments(150);
    wait_drained();

    random_box(4);
    random_segments(200);
    wait_drained();

    random_box(1 << 24);
    random_segments(400);
    wait_drained();

    repeat (sbcp_pkg::FracBits + 20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
